### rtl/arpc_pkg.sv
// Shared constants, codes and control structs for the ARP cache engine.
`timescale 1ns / 1ps

package arpc_pkg;

   // Cache geometry
   localparam int ENTRIES = 8;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Field widths
   localparam int OP_W   = 2;
   localparam int HALF_W = 16;
   localparam int IP_W   = 32;
   localparam int MAC_W  = 48;

   // Stream payload widths
   localparam int REQ_DATA_W = 4 * HALF_W + 3 * IP_W + MAC_W;   // 208, whole bytes
   localparam int RSP_DATA_W = 2 * MAC_W + IP_W;                // 128, whole bytes
   localparam int RSP_USER_W = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Operation codes
   localparam logic [OP_W-1:0] OP_RECEIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_RESOLVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

   // Protocol constants
   localparam logic [HALF_W-1:0] MIN_FRAME   = 16'(14 + 28);
   localparam logic [HALF_W-1:0] HW_ETHERNET = 16'h0001;
   localparam logic [HALF_W-1:0] PROTO_IPV4  = 16'h0800;
   localparam logic [HALF_W-1:0] ARP_REQUEST = 16'h0001;
   localparam logic [IP_W-1:0]   IP_BCAST    = 32'hFFFF_FFFF;
   localparam int                MAC_GROUP_BIT = 40;

   // Controller to datapath
   typedef struct packed {
      logic load;   // capture the accepted request
      logic exec;   // look up, write back and load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_blocked;   // result register full and not being taken
   } status_type;

endpackage

### rtl/arpc_ctrl.sv
// Controller state machine: sequences capture and execute of one request.
`timescale 1ns / 1ps

module arpc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  arpc_pkg::status_type status,
   output arpc_pkg::cmd_type    cmd
);
   import arpc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            // take nothing while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold until the result register can take a new result
            if (!status.out_blocked) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/arpc_datapath.sv
// Datapath: request capture, cache entries, parallel compare, result register, CSR.
`timescale 1ns / 1ps

module arpc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  arpc_pkg::cmd_type                 cmd,
   output arpc_pkg::status_type              status,
   input  logic [arpc_pkg::OP_W-1:0]         req_op,
   input  logic [arpc_pkg::REQ_DATA_W-1:0]   req_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [arpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [arpc_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [arpc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [arpc_pkg::CSR_DATA_W-1:0]   csr_prdata
);
   import arpc_pkg::*;

   // Captured request
   logic [OP_W-1:0]   op_ff;
   logic [HALF_W-1:0] frame_len_ff, hw_type_ff, proto_type_ff, arp_oper_ff;
   logic [IP_W-1:0]   src_ip_ff, dst_ip_ff, lookup_ip_ff;
   logic [MAC_W-1:0]  src_mac_ff;

   // Cache
   logic [IP_W-1:0]  entry_ip_ff  [ENTRIES];
   logic [MAC_W-1:0] entry_mac_ff [ENTRIES];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [IP_W-1:0] our_ip_ff, our_ip_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic             send_request_ff, send_request_in;
   logic             send_reply_ff, send_reply_in;
   logic [MAC_W-1:0] found_mac_ff, found_mac_in;
   logic [MAC_W-1:0] reply_mac_ff, reply_mac_in;
   logic [IP_W-1:0]  peer_ip_ff, peer_ip_in;

   logic [IP_W-1:0]  cmp_ip;
   logic [ENTRIES-1:0] match;
   logic             hit;
   logic [IDX_W-1:0] hit_idx;
   logic             pkt_ok, learnable;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic             wr_ip_en;
   logic             csr_wr;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= req_op;
         frame_len_ff  <= req_data[15:0];
         hw_type_ff    <= req_data[31:16];
         proto_type_ff <= req_data[47:32];
         arp_oper_ff   <= req_data[63:48];
         src_ip_ff     <= req_data[95:64];
         src_mac_ff    <= req_data[143:96];
         dst_ip_ff     <= req_data[175:144];
         lookup_ip_ff  <= req_data[207:176];
      end
   end

   // Parallel compare over live entries, lowest index wins
   assign cmp_ip = (op_ff == OP_RECEIVE) ? src_ip_ff : lookup_ip_ff;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (entry_ip_ff[i] == cmp_ip);
      end
   end

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign pkt_ok = (frame_len_ff >= MIN_FRAME) && (hw_type_ff == HW_ETHERNET)
                   && (proto_type_ff == PROTO_IPV4);
   assign learnable = (src_ip_ff != '0) && (src_ip_ff != IP_BCAST)
                      && (src_mac_ff != '0) && !src_mac_ff[MAC_GROUP_BIT];

   always_comb begin
      count_in        = count_ff;
      wr_en           = 1'b0;
      wr_ip_en        = 1'b0;
      wr_idx          = '0;
      found_in        = 1'b0;
      found_mac_in    = '0;
      send_request_in = 1'b0;
      send_reply_in   = 1'b0;
      reply_mac_in    = '0;
      peer_ip_in      = '0;
      case (op_ff)
         OP_RECEIVE: begin
            if (pkt_ok) begin
               if (learnable) begin
                  wr_en = 1'b1;
                  if (hit) begin
                     wr_idx = hit_idx;
                  end else if (count_ff < CNT_W'(ENTRIES)) begin
                     wr_ip_en = 1'b1;
                     wr_idx   = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     wr_ip_en = 1'b1;   // full: overwrite slot 0
                  end
               end
               if ((arp_oper_ff == ARP_REQUEST) && (dst_ip_ff == our_ip_ff)) begin
                  send_reply_in = 1'b1;
                  reply_mac_in  = src_mac_ff;
                  peer_ip_in    = src_ip_ff;
               end
            end
         end
         OP_RESOLVE: begin
            if (our_ip_ff != '0) begin
               if (hit) begin
                  found_in     = 1'b1;
                  found_mac_in = entry_mac_ff[hit_idx];
               end else begin
                  send_request_in = 1'b1;
                  peer_ip_in      = lookup_ip_ff;
               end
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Entry storage, no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         entry_mac_ff[wr_idx] <= src_mac_ff;
         if (wr_ip_en) begin
            entry_ip_ff[wr_idx] <= src_ip_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         found_ff        <= found_in;
         found_mac_ff    <= found_mac_in;
         send_request_ff <= send_request_in;
         send_reply_ff   <= send_reply_in;
         reply_mac_ff    <= reply_mac_in;
         peer_ip_ff      <= peer_ip_in;
      end
   end

   assign status.out_blocked = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {peer_ip_ff, reply_mac_ff, found_mac_ff};
   assign rsp_tuser  = {send_reply_ff, send_request_ff, found_ff};

   // Configuration register
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];

   always_comb begin
      our_ip_in = our_ip_ff;
      if (csr_wr) begin
         our_ip_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         our_ip_ff <= '0;
      end else begin
         our_ip_ff <= our_ip_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : our_ip_ff;

endmodule

### rtl/arp_cache_engine.sv
// Top level of the ARP cache engine: controller, datapath and port wiring.
`timescale 1ns / 1ps

// An 8-entry IPv4-to-MAC cache with ARP receive handling. Each request
// transfer carries an operation in req_tuser (receive, resolve, clear) and
// gives exactly one response transfer. A request is handled in two steps:
// capture, then the parallel compare of all entries and the write-back,
// which also loads the response register. The next request is taken in
// the cycle after the execute step, so none is accepted while one is in
// flight; a response left waiting in the response register holds the
// execute step until it is taken. The entry store needs no clearing pass:
// a live-entry count decides which entries are read. Write our_ip over the
// CSR port (byte address 0) only while no request is in flight.
module arp_cache_engine (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_len[15:0], hw_type[31:16], proto_type[47:32], arp_oper[63:48],
   // src_ip[95:64], src_mac[143:96], dst_ip[175:144],
   // lookup_ip[207:176]
   input  logic [arpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op[1:0]
   input  logic [arpc_pkg::OP_W-1:0]         req_tuser,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found_mac[47:0], reply_mac[95:48], peer_ip[127:96]
   output logic [arpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found[0], send_request[1], send_reply[2]
   output logic [arpc_pkg::RSP_USER_W-1:0]   rsp_tuser,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [arpc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [arpc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import arpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Zero-wait-state register port
   assign csr_pready = 1'b1;

   // Sequence capture and execute
   arpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the cache, compare, write back and drive the response
   arpc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_op      (req_tuser),
      .req_data    (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

### rtl/arpc_checker.sv
// Port-level assertions for the ARP cache engine and their bind.
`timescale 1ns / 1ps

module arpc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [arpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [arpc_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import arpc_pkg::*;

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One request at a time: no transfer in the cycle after a transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one executes");

   // At most one of hit, request and reply
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tuser))
      else $error("more than one response flag set");

   // A response without a hit carries a zero MAC
   a_miss_zero_mac: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[MAC_W-1:0] == '0)
      else $error("MAC present without a hit");

   // Reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind arp_cache_engine arpc_checker u_arpc_checker (.*);
